/* rtl/cfdf_pkg.sv */
package cfdf_pkg;

   // sizes of the filter
   localparam int MAX_TAPS    = 7;
   localparam int SAMPLE_BITS = 8;
   localparam int COEF_BITS   = 16;
   localparam int FRAC_BITS   = 14;

   // derived widths
   localparam int TAP_BITS  = $clog2(MAX_TAPS + 1);
   localparam int FILL_BITS = $clog2(MAX_TAPS + 1);
   localparam int IDX_BITS  = $clog2(MAX_TAPS);
   localparam int E_BITS    = $clog2(MAX_TAPS / 2 + 1);
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + $clog2(MAX_TAPS);
   localparam int Q_BITS    = ACC_BITS - FRAC_BITS;
   localparam int REG_BITS  = $clog2(MAX_TAPS + 1);

   // saturation bounds of one output part
   localparam int SAT_HI = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam int SAT_LO = -(2 ** (SAMPLE_BITS - 1));

   // register map
   localparam logic [REG_BITS-1:0] REG_TAPS  = REG_BITS'(0);
   localparam logic [REG_BITS-1:0] REG_COEF0 = REG_BITS'(1);

   // reset values of the register file
   localparam logic [TAP_BITS-1:0] TAPS_RESET  = TAP_BITS'(5);
   localparam int                  UNITY_TAP   = 2;
   localparam logic [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(2 ** FRAC_BITS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   typedef sample_type window_type [MAX_TAPS];
   typedef coef_type   coef_array_type [MAX_TAPS];

   // one output job: distance behind the newest sample, and end-of-block flag
   typedef struct packed {
      logic [E_BITS-1:0] e;
      logic              last;
   } job_type;

endpackage

/* rtl/cfdf_mac.sv */
module cfdf_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  cfdf_pkg::job_type                   job,
   output logic                                job_ready,
   input  cfdf_pkg::window_type                window_real,
   input  cfdf_pkg::window_type                window_imag,
   input  cfdf_pkg::coef_array_type            coefs,
   input  logic [cfdf_pkg::TAP_BITS-1:0]       taps,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cfdf_pkg::SAMPLE_BITS-1:0] rsp_out_real,
   output logic signed [cfdf_pkg::SAMPLE_BITS-1:0] rsp_out_imag,
   output logic                                rsp_out_last
);

   // round half up, then clamp to the sample range
   function automatic cfdf_pkg::sample_type round_sat(input cfdf_pkg::acc_type acc);
      cfdf_pkg::acc_type                        v;
      logic signed [cfdf_pkg::Q_BITS-1:0]       q;
      cfdf_pkg::sample_type                     r;
      v = acc + cfdf_pkg::acc_type'(2 ** (cfdf_pkg::FRAC_BITS - 1));
      q = $signed(v[cfdf_pkg::ACC_BITS-1:cfdf_pkg::FRAC_BITS]);
      if (q > cfdf_pkg::Q_BITS'(cfdf_pkg::SAT_HI)) begin
         r = cfdf_pkg::SAMPLE_BITS'(cfdf_pkg::SAT_HI);
      end else if (q < cfdf_pkg::Q_BITS'(cfdf_pkg::SAT_LO)) begin
         r = cfdf_pkg::SAMPLE_BITS'(cfdf_pkg::SAT_LO);
      end else begin
         r = cfdf_pkg::sample_type'(q);
      end
      return r;
   endfunction

   logic                                 out_ready;
   logic                                 prod_adv;
   logic [cfdf_pkg::TAP_BITS-1:0]        half;
   logic [cfdf_pkg::IDX_BITS-1:0]        align;
   cfdf_pkg::prod_type                   prod_real_in [cfdf_pkg::MAX_TAPS];
   cfdf_pkg::prod_type                   prod_imag_in [cfdf_pkg::MAX_TAPS];
   cfdf_pkg::prod_type                   prod_real_ff [cfdf_pkg::MAX_TAPS];
   cfdf_pkg::prod_type                   prod_imag_ff [cfdf_pkg::MAX_TAPS];
   logic                                 prod_vld_ff;
   logic                                 prod_last_ff;
   cfdf_pkg::acc_type                    acc_real;
   cfdf_pkg::acc_type                    acc_imag;
   logic                                 out_vld_ff;
   logic                                 out_last_ff;
   cfdf_pkg::sample_type                 out_real_ff;
   cfdf_pkg::sample_type                 out_imag_ff;

   // stage handshake: a stage moves when the next one is empty or moving
   assign out_ready = !out_vld_ff || !rsp_stall;
   assign prod_adv  = !prod_vld_ff || out_ready;
   assign job_ready = prod_adv;

   // tap k reads the sample align - k behind the newest one
   assign half  = taps >> 1;
   assign align = cfdf_pkg::IDX_BITS'(job.e) + cfdf_pkg::IDX_BITS'(half);

   always_comb begin
      for (int k = 0; k < cfdf_pkg::MAX_TAPS; k++) begin
         prod_real_in[k] = '0;
         prod_imag_in[k] = '0;
         if ((cfdf_pkg::TAP_BITS'(k) < taps) && (cfdf_pkg::IDX_BITS'(k) <= align)) begin
            prod_real_in[k] = cfdf_pkg::prod_type'($signed(coefs[k]))
               * cfdf_pkg::prod_type'($signed(window_real[align - cfdf_pkg::IDX_BITS'(k)]));
            prod_imag_in[k] = cfdf_pkg::prod_type'($signed(coefs[k]))
               * cfdf_pkg::prod_type'($signed(window_imag[align - cfdf_pkg::IDX_BITS'(k)]));
         end
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (prod_adv) begin
         prod_vld_ff <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_adv) begin
         prod_last_ff <= job.last;
         prod_real_ff <= prod_real_in;
         prod_imag_ff <= prod_imag_in;
      end
   end

   // accumulate the products
   always_comb begin
      acc_real = '0;
      acc_imag = '0;
      for (int k = 0; k < cfdf_pkg::MAX_TAPS; k++) begin
         acc_real = acc_real + cfdf_pkg::acc_type'(prod_real_ff[k]);
         acc_imag = acc_imag + cfdf_pkg::acc_type'(prod_imag_ff[k]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_last_ff <= prod_last_ff;
         out_real_ff <= round_sat(acc_real);
         out_imag_ff <= round_sat(acc_imag);
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_out_real = out_real_ff;
   assign rsp_out_imag = out_imag_ff;
   assign rsp_out_last = out_last_ff;

endmodule

/* rtl/complex_fractional_delay_fir_core.sv */
// Centred complex FIR on 8-bit I/Q samples with zero padding at block edges.
// Request channel (req_): one complex sample per beat, req_last_sample ends a
// block. A beat is taken on a rising edge with req_valid high and req_stall low.
// Response channel (rsp_): one filtered sample per beat, rsp_out_last marks the
// final output of a block; taken when rsp_valid is high and rsp_stall low.
// Register channel (csr_): index 0 sets the tap count, 1 to 7 the Q1.14
// coefficients; csr_ready is always high, writes belong in idle periods.
// Throughput is one sample per cycle while nothing stalls. A response beat is
// registered in turn in the job, product and result registers after its request.
// A last sample releases up to taps/2 + 1 outputs, one per cycle from the job
// register while the MAC takes them, and req_stall stays high while the flush runs;
// the delay line is then cleared.
// When the receiver stalls, the pipeline fills its bubbles first and then raises
// req_stall; no beat is lost.
// Synchronous reset clears the delay line and all pipeline valids, sets the tap
// count to 5 and the coefficients to a unit centre tap.
module complex_fractional_delay_fir_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [cfdf_pkg::SAMPLE_BITS-1:0]  req_sample_real,
   input  logic signed [cfdf_pkg::SAMPLE_BITS-1:0]  req_sample_imag,
   input  logic                                     req_last_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cfdf_pkg::SAMPLE_BITS-1:0]  rsp_out_real,
   output logic signed [cfdf_pkg::SAMPLE_BITS-1:0]  rsp_out_imag,
   output logic                                     rsp_out_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [cfdf_pkg::REG_BITS-1:0]            csr_index,
   input  logic [cfdf_pkg::COEF_BITS-1:0]           csr_wdata
);

   logic [cfdf_pkg::TAP_BITS-1:0]   taps_ff;
   cfdf_pkg::coef_array_type        coef_ff;
   cfdf_pkg::window_type            win_real_ff;
   cfdf_pkg::window_type            win_imag_ff;
   cfdf_pkg::window_type            win_real_in;
   cfdf_pkg::window_type            win_imag_in;
   logic [cfdf_pkg::FILL_BITS-1:0]  fill_ff;
   logic [cfdf_pkg::FILL_BITS-1:0]  fill_in;
   logic [cfdf_pkg::FILL_BITS-1:0]  fill_next;
   logic                            job_vld_ff;
   logic                            job_vld_in;
   cfdf_pkg::job_type               job_ff;
   cfdf_pkg::job_type               job_in;
   logic                            flush_ff;
   logic                            flush_in;
   logic                            mac_ready;
   logic                            job_free;
   logic                            accept;
   logic [cfdf_pkg::TAP_BITS-1:0]   half;
   logic [cfdf_pkg::E_BITS-1:0]     emax;
   logic [cfdf_pkg::REG_BITS-1:0]   coef_sel;

   // register file
   assign csr_ready = 1'b1;
   assign coef_sel  = csr_index - cfdf_pkg::REG_COEF0;

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= cfdf_pkg::TAPS_RESET;
         for (int k = 0; k < cfdf_pkg::MAX_TAPS; k++) begin
            coef_ff[k] <= (k == cfdf_pkg::UNITY_TAP) ? cfdf_pkg::COEF_UNITY : '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cfdf_pkg::REG_TAPS: begin
               taps_ff <= csr_wdata[cfdf_pkg::TAP_BITS-1:0];
            end
            default: begin
               coef_ff[coef_sel[cfdf_pkg::IDX_BITS-1:0]] <= csr_wdata;
            end
         endcase
      end
   end

   // input handshake: hold off while the job register is busy or flushing
   assign job_free  = !job_vld_ff || mac_ready;
   assign req_stall = !job_free || (job_vld_ff && flush_ff);
   assign accept    = req_valid && !req_stall;

   // fill level after this sample, and the oldest output still owed
   assign half      = taps_ff >> 1;
   assign fill_next = (fill_ff == cfdf_pkg::FILL_BITS'(cfdf_pkg::MAX_TAPS)) ?
                      fill_ff : fill_ff + 1'b1;
   assign emax      = (fill_next > half) ? cfdf_pkg::E_BITS'(half) :
                      cfdf_pkg::E_BITS'(fill_next - 1'b1);

   // delay line, fill count and job control
   always_comb begin
      win_real_in = win_real_ff;
      win_imag_in = win_imag_ff;
      fill_in     = fill_ff;
      job_vld_in  = job_vld_ff;
      job_in      = job_ff;
      flush_in    = flush_ff;
      if (accept) begin
         for (int d = cfdf_pkg::MAX_TAPS - 1; d > 0; d--) begin
            win_real_in[d] = win_real_ff[d-1];
            win_imag_in[d] = win_imag_ff[d-1];
         end
         win_real_in[0] = req_sample_real;
         win_imag_in[0] = req_sample_imag;
         if (req_last_sample) begin
            // flush: walk outputs from oldest to newest
            fill_in     = '0;
            job_vld_in  = 1'b1;
            job_in.e    = emax;
            job_in.last = (emax == '0);
            flush_in    = 1'b1;
         end else begin
            fill_in     = fill_next;
            job_vld_in  = (fill_next > half);
            job_in.e    = cfdf_pkg::E_BITS'(half);
            job_in.last = 1'b0;
            flush_in    = 1'b0;
         end
      end else if (job_vld_ff && mac_ready) begin
         if (flush_ff && (job_ff.e != '0)) begin
            job_in.e    = job_ff.e - 1'b1;
            job_in.last = (job_ff.e == cfdf_pkg::E_BITS'(1));
         end else begin
            job_vld_in = 1'b0;
            flush_in   = 1'b0;
            // block done: clear the delay line
            if (flush_ff) begin
               for (int d = 0; d < cfdf_pkg::MAX_TAPS; d++) begin
                  win_real_in[d] = '0;
                  win_imag_in[d] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < cfdf_pkg::MAX_TAPS; d++) begin
            win_real_ff[d] <= '0;
            win_imag_ff[d] <= '0;
         end
         fill_ff    <= '0;
         job_vld_ff <= 1'b0;
         job_ff     <= '0;
         flush_ff   <= 1'b0;
      end else begin
         win_real_ff <= win_real_in;
         win_imag_ff <= win_imag_in;
         fill_ff     <= fill_in;
         job_vld_ff  <= job_vld_in;
         job_ff      <= job_in;
         flush_ff    <= flush_in;
      end
   end

   // multiply, accumulate, round and saturate
   cfdf_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_vld_ff),
      .job          (job_ff),
      .job_ready    (mac_ready),
      .window_real  (win_real_ff),
      .window_imag  (win_imag_ff),
      .coefs        (coef_ff),
      .taps         (taps_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_real (rsp_out_real),
      .rsp_out_imag (rsp_out_imag),
      .rsp_out_last (rsp_out_last)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int WIN_DEPTH      = cfdf_pkg::MAX_TAPS + 1;
   localparam int PIPE_SLACK     = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_GAP        = 40;

   typedef struct packed {
      cfdf_pkg::sample_type re;
      cfdf_pkg::sample_type im;
      logic                 last;
   } fir_out_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // block ports
   logic                           req_valid       = 1'b0;
   logic                           req_stall;
   cfdf_pkg::sample_type           req_sample_real = '0;
   cfdf_pkg::sample_type           req_sample_imag = '0;
   logic                           req_last_sample = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall       = 1'b0;
   cfdf_pkg::sample_type           rsp_out_real;
   cfdf_pkg::sample_type           rsp_out_imag;
   logic                           rsp_out_last;
   logic                           csr_valid       = 1'b0;
   logic                           csr_ready;
   logic [cfdf_pkg::REG_BITS-1:0]  csr_index       = '0;
   logic [cfdf_pkg::COEF_BITS-1:0] csr_wdata       = '0;

   complex_fractional_delay_fir_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_real (req_sample_real),
      .req_sample_imag (req_sample_imag),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_real    (rsp_out_real),
      .rsp_out_imag    (rsp_out_imag),
      .rsp_out_last    (rsp_out_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // shadow copy of the filter: registers, delay line and owed outputs
   logic [cfdf_pkg::TAP_BITS-1:0] taps_reg = cfdf_pkg::TAPS_RESET;
   cfdf_pkg::coef_type            coef_reg [cfdf_pkg::MAX_TAPS];
   cfdf_pkg::sample_type          line_re  [WIN_DEPTH];
   cfdf_pkg::sample_type          line_im  [WIN_DEPTH];
   int                            fill = 0;
   fir_out_type                   owed_q [$];

   int fail_count    = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   initial begin
      foreach (coef_reg[k]) coef_reg[k] = '0;
      coef_reg[cfdf_pkg::UNITY_TAP] = cfdf_pkg::COEF_UNITY;
      foreach (line_re[d]) begin
         line_re[d] = '0;
         line_im[d] = '0;
      end
   end

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   // round half up, then clip to a signed byte
   function automatic cfdf_pkg::sample_type round_to_byte(longint acc);
      longint q;
      q = (acc + (longint'(1) <<< (cfdf_pkg::FRAC_BITS - 1))) >>> cfdf_pkg::FRAC_BITS;
      if (q > cfdf_pkg::SAT_HI) q = cfdf_pkg::SAT_HI;
      if (q < cfdf_pkg::SAT_LO) q = cfdf_pkg::SAT_LO;
      return cfdf_pkg::sample_type'(q);
   endfunction

   // output lying e samples behind the newest one
   function automatic fir_out_type filter_at(int t, int e, logic last);
      int          h;
      int          d;
      longint      acc_re;
      longint      acc_im;
      fir_out_type r;
      h = t / 2;
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < t; k++) begin
         d = e + h - k;
         if (d >= 0 && d < WIN_DEPTH) begin
            acc_re += longint'(coef_reg[k]) * longint'(line_re[d]);
            acc_im += longint'(coef_reg[k]) * longint'(line_im[d]);
         end
      end
      r.re = round_to_byte(acc_re);
      r.im = round_to_byte(acc_im);
      r.last = last;
      return r;
   endfunction

   // advance the shadow delay line by one accepted sample
   function automatic void predict_sample(cfdf_pkg::sample_type re, cfdf_pkg::sample_type im,
                                          logic last);
      int t;
      int h;
      int emax;
      t = int'(taps_reg);
      if (t > cfdf_pkg::MAX_TAPS) t = cfdf_pkg::MAX_TAPS;
      h = t / 2;
      for (int d = WIN_DEPTH - 1; d > 0; d--) begin
         line_re[d] = line_re[d - 1];
         line_im[d] = line_im[d - 1];
      end
      line_re[0] = re;
      line_im[0] = im;
      if (fill < cfdf_pkg::MAX_TAPS) fill++;
      if (last) begin
         emax = (fill > h) ? h : fill - 1;
         for (int i = 0; i <= emax; i++) begin
            owed_q.push_back(filter_at(t, emax - i, (emax - i) == 0));
         end
         foreach (line_re[d]) begin
            line_re[d] = '0;
            line_im[d] = '0;
         end
         fill = 0;
      end else if (fill > h) begin
         owed_q.push_back(filter_at(t, h, 1'b0));
      end
   endfunction

   // result side: check every accepted beat against the oldest owed output
   always @(posedge clock) begin : check_beats
      fir_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_q.size() == 0) begin
            note_failure($sformatf("unexpected beat: re=%0d im=%0d last=%0b",
                                   rsp_out_real, rsp_out_imag, rsp_out_last));
         end else begin
            want = owed_q.pop_front();
            if (rsp_out_real !== want.re || rsp_out_imag !== want.im ||
                rsp_out_last !== want.last) begin
               note_failure($sformatf(
                  "mismatch: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                  want.re, want.im, want.last, rsp_out_real, rsp_out_imag, rsp_out_last));
            end
         end
      end
   end

   // receiver stall: long hold-off when asked, random otherwise
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one sample beat, with a random gap in front; valid stays high afterwards
   task automatic send_sample(cfdf_pkg::sample_type re, cfdf_pkg::sample_type im, logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_real <= re;
      req_sample_imag <= im;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sample(re, im, last);
   endtask

   // one sample beat from plain integer values
   task automatic send_value(int re, int im, logic last);
      send_sample(cfdf_pkg::sample_type'(re), cfdf_pkg::sample_type'(im), last);
   endtask

   function automatic cfdf_pkg::sample_type rand_sample();
      case ($urandom_range(9))
         0:       return cfdf_pkg::sample_type'(cfdf_pkg::SAT_LO);
         1:       return cfdf_pkg::sample_type'(cfdf_pkg::SAT_HI);
         default: return cfdf_pkg::sample_type'($urandom);
      endcase
   endfunction

   function automatic cfdf_pkg::coef_type rand_coef();
      case ($urandom_range(5))
         0:       return cfdf_pkg::coef_type'(16'h8000);
         1:       return cfdf_pkg::coef_type'(16'h7fff);
         2, 3:    return cfdf_pkg::coef_type'($urandom);
         default: return cfdf_pkg::coef_type'($urandom_range(16383) - 8192);
      endcase
   endfunction

   task automatic send_block(int len);
      for (int i = 0; i < len; i++) begin
         send_sample(rand_sample(), rand_sample(), i == len - 1);
      end
   endtask

   // stop sending and wait until every owed output has come out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_q.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(logic [cfdf_pkg::REG_BITS-1:0] idx,
                            logic [cfdf_pkg::COEF_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == cfdf_pkg::REG_TAPS)
         taps_reg = val[cfdf_pkg::TAP_BITS-1:0];
      else
         coef_reg[idx - cfdf_pkg::REG_COEF0] = val;
      @(posedge clock);
   endtask

   // new tap count and coefficients, only once the filter is idle
   task automatic load_setting(int taps, cfdf_pkg::coef_array_type c);
      settle();
      write_reg(cfdf_pkg::REG_TAPS,
                (cfdf_pkg::COEF_BITS'($urandom) << cfdf_pkg::TAP_BITS) |
                cfdf_pkg::COEF_BITS'(taps));
      for (int k = 0; k < cfdf_pkg::MAX_TAPS; k++) begin
         write_reg(cfdf_pkg::REG_COEF0 + cfdf_pkg::REG_BITS'(k), c[k]);
      end
   endtask

   // reset registers: five taps, unit centre tap
   task automatic test_reset_state();
      send_value(-128, 127, 1'b0);
      send_value(127, -128, 1'b0);
      send_value(0, -1, 1'b0);
      send_value(-1, 0, 1'b0);
      send_value(85, -86, 1'b1);
   endtask

   // full-scale coefficients and samples, both saturation limits
   task automatic test_saturation();
      cfdf_pkg::coef_array_type c;
      c = '{default: cfdf_pkg::coef_type'(16'h7fff)};
      load_setting(7, c);
      send_value(127, -128, 1'b0);
      send_value(127, -128, 1'b0);
      send_value(-128, 127, 1'b0);
      send_value(127, 127, 1'b1);
      c = '{default: cfdf_pkg::coef_type'(16'h8000)};
      load_setting(7, c);
      send_value(-128, -128, 1'b0);
      send_value(127, -128, 1'b0);
      send_value(-128, 127, 1'b1);
   endtask

   // half-way values round upwards
   task automatic test_rounding();
      cfdf_pkg::coef_array_type c;
      c = '{default: cfdf_pkg::coef_type'(0)};
      c[0] = cfdf_pkg::coef_type'(8192);
      load_setting(1, c);
      send_value(1, -1, 1'b0);
      send_value(3, -3, 1'b1);
   endtask

   // no taps: one zero output per sample
   task automatic test_zero_taps();
      cfdf_pkg::coef_array_type c;
      foreach (c[k]) c[k] = rand_coef();
      load_setting(0, c);
      send_value(100, -100, 1'b0);
      send_value(-128, 127, 1'b0);
      send_value(55, 1, 1'b1);
   endtask

   // even tap counts and blocks shorter than half the filter
   task automatic test_even_taps();
      cfdf_pkg::coef_array_type c;
      foreach (c[k]) c[k] = rand_coef();
      load_setting(6, c);
      send_block(4);
      send_block(2);
      foreach (c[k]) c[k] = rand_coef();
      load_setting(4, c);
      send_block(1);
   endtask

   // receiver holds off long enough for the input to stall
   task automatic test_backpressure();
      cfdf_pkg::coef_array_type c;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      foreach (c[k]) c[k] = rand_coef();
      load_setting(7, c);
      hold_left = 100;
      send_block(40);
   endtask

   // sender waits mid-block until the filter has drained
   task automatic test_sender_pause();
      for (int i = 0; i < 8; i++) send_sample(rand_sample(), rand_sample(), 1'b0);
      settle();
      send_block(8);
   endtask

   // random blocks under a range of settings
   task automatic test_random_traffic(int send_pct, int rsp_pct, int n_items);
      cfdf_pkg::coef_array_type c;
      int sent;
      int per_set;
      int len;
      int set_no;
      int taps;
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      sent = 0;
      set_no = 0;
      while (sent < n_items) begin
         foreach (c[k]) c[k] = rand_coef();
         taps = (set_no == 0) ? 1 : (set_no == 1) ? cfdf_pkg::MAX_TAPS :
                $urandom_range(cfdf_pkg::MAX_TAPS);
         load_setting(taps, c);
         per_set = $urandom_range(25, 60);
         while (per_set > 0) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            send_block(len);
            per_set -= len;
            sent += len;
         end
         set_no++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_saturation();
      test_rounding();
      test_zero_taps();
      test_even_taps();
      test_backpressure();
      test_sender_pause();
      test_random_traffic(32, 81, 100);
      test_random_traffic(81, 32, 100);
      test_random_traffic(0, 0, 100);
      settle();
      if (owed_q.size() != 0)
         note_failure($sformatf("%0d outputs never arrived", owed_q.size()));
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
